>>> hdl/rcfc_pkg.sv
// ----------------------------------------------------------------------------
// Radio command frame controller package
// Shared types and constants for the frame checker, the control logic and the
// top level.
// ----------------------------------------------------------------------------
package rcfc_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam int unsigned CntW     = 5;
  localparam int unsigned CntCap   = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgW     = 16;

  typedef enum logic [2:0] {
    StNone     = 3'd0,
    StAccepted = 3'd1,
    StBadLen   = 3'd2,
    StBadAddr  = 3'd3,
    StBadSum   = 3'd4
  } frame_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSyncWord    = 3'd0,
    RegOwnId       = 3'd1,
    RegBroadcastId = 3'd2,
    RegCodeMotorOn = 3'd3,
    RegCodeMotorOff = 3'd4,
    RegCodeTelem   = 3'd5,
    RegFailsafeMs  = 3'd6,
    RegTelemPeriod = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] own_id;
    logic [15:0] broadcast_id;
    logic [7:0]  code_drive_on;
    logic [7:0]  code_motor_off;
    logic [7:0]  code_telemetry;
    logic [15:0] failsafe_ms;
    logic [15:0] telemetry_period_ms;
  } cfg_t;

  typedef struct packed {
    frame_status_e status;
    logic          bcast;
    logic [7:0]    cmd;
  } frame_chk_t;

  typedef struct packed {
    logic          drive_on;
    logic          telemetry_send;
    logic          tone_change;
    logic          tone_broadcast;
    frame_status_e frame_status;
  } result_t;

endpackage

>>> hdl/rcfc_frame.sv
// ----------------------------------------------------------------------------
// Frame buffer and checker
// Collects received bytes, counts the frame length and checks length, sync
// word, identifier and checksum when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module rcfc_frame import rcfc_pkg::*; #(
  parameter int unsigned MaxRxBytes = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_en_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_last_i,
  input  cfg_t       cfg_i,
  output frame_chk_t chk_o
);

  localparam int unsigned CntMax = (MaxRxBytes < CntCap) ? MaxRxBytes : CntCap;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      bytes_q [FrameLen];
  logic [7:0]      bytes_d [FrameLen];
  logic [15:0]     sync_val, id_val;
  logic [7:0]      xor_val;

  always_comb begin
    bytes_d = bytes_q;
    if (cnt_q < CntW'(FrameLen)) begin
      bytes_d[cnt_q[IdxW-1:0]] = rx_byte_i;
    end
    cnt_inc = (cnt_q < CntW'(CntMax)) ? cnt_q + CntW'(1) : cnt_q;
    cnt_d   = rx_last_i ? '0 : cnt_inc;
  end

  always_comb begin
    sync_val = {bytes_d[0], bytes_d[1]};
    id_val   = {bytes_d[2], bytes_d[3]};
    xor_val  = '0;
    for (int i = 0; i < FrameLen - 1; i++) begin
      xor_val = xor_val ^ bytes_d[i];
    end
    chk_o.bcast = (id_val == cfg_i.broadcast_id);
    chk_o.cmd   = bytes_d[4];
    if (cnt_inc != CntW'(FrameLen)) begin
      chk_o.status = StBadLen;
    end else if ((sync_val != cfg_i.sync_word) ||
                 ((id_val != cfg_i.own_id) && (id_val != cfg_i.broadcast_id))) begin
      chk_o.status = StBadAddr;
    end else if (xor_val != bytes_d[FrameLen-1]) begin
      chk_o.status = StBadSum;
    end else begin
      chk_o.status = StAccepted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (byte_en_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en_i) begin
      bytes_q <= bytes_d;
    end
  end

endmodule

>>> hdl/rcfc_ctrl.sv
// ----------------------------------------------------------------------------
// Command and timer control
// Holds motor and tone mode state and the millisecond timers for failsafe,
// periodic telemetry and delayed telemetry, and forms each result.
// ----------------------------------------------------------------------------
module rcfc_ctrl import rcfc_pkg::*; #(
  parameter int unsigned ReqDelayMs = 300
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       proc_i,
  input  logic       op_i,
  input  logic       rx_last_i,
  input  frame_chk_t chk_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  logic        motor_q, motor_d;
  logic        mode_q, mode_d;
  logic [15:0] msf_q, msf_d;
  logic [15:0] msp_q, msp_d;
  logic        req_q, req_d;
  logic [15:0] age_q, age_d;
  logic [15:0] msf_inc, msp_inc, age_inc;
  logic        send, tone_chg;
  frame_status_e status;

  always_comb begin
    msf_inc  = (msf_q == 16'hFFFF) ? msf_q : msf_q + 16'd1;
    msp_inc  = (msp_q == 16'hFFFF) ? msp_q : msp_q + 16'd1;
    age_inc  = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
    motor_d  = motor_q;
    mode_d   = mode_q;
    msf_d    = msf_q;
    msp_d    = msp_q;
    req_d    = req_q;
    age_d    = age_q;
    send     = 1'b0;
    tone_chg = 1'b0;
    status   = StNone;
    if (!op_i) begin
      msf_d = msf_inc;
      msp_d = msp_inc;
      age_d = age_inc;
      if (msf_inc > cfg_i.failsafe_ms) begin
        motor_d = 1'b0;
      end
      if (msp_inc > cfg_i.telemetry_period_ms) begin
        msp_d = '0;
        send  = 1'b1;
      end else if (req_q && (age_inc >= 16'(ReqDelayMs))) begin
        req_d = 1'b0;
        send  = 1'b1;
      end
    end else if (rx_last_i) begin
      status = chk_i.status;
      if (chk_i.status == StAccepted) begin
        mode_d   = chk_i.bcast;
        tone_chg = (chk_i.bcast != mode_q);
        if (chk_i.cmd == cfg_i.code_drive_on) begin
          motor_d = 1'b1;
        end else if (chk_i.cmd == cfg_i.code_motor_off) begin
          motor_d = 1'b0;
        end else if (chk_i.cmd == cfg_i.code_telemetry) begin
          req_d = 1'b1;
          age_d = '0;
        end
        msf_d = '0;
      end
    end
  end

  always_comb begin
    res_o.drive_on       = motor_d;
    res_o.telemetry_send = send;
    res_o.tone_change    = tone_chg;
    res_o.tone_broadcast = mode_d;
    res_o.frame_status   = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q <= 1'b0;
      mode_q  <= 1'b0;
      msf_q   <= '0;
      msp_q   <= '0;
      req_q   <= 1'b0;
      age_q   <= '0;
    end else if (proc_i) begin
      motor_q <= motor_d;
      mode_q  <= mode_d;
      msf_q   <= msf_d;
      msp_q   <= msp_d;
      req_q   <= req_d;
      age_q   <= age_d;
    end
  end

endmodule

>>> hdl/radio_command_frame_controller.sv
// ----------------------------------------------------------------------------
// Radio command frame controller
// Checks received radio command frames, drives the motor and tone mode and
// schedules telemetry from millisecond ticks.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   op, rx_byte, rx_last
//   out      source     out_valid_o / out_stall_i drive_on, telemetry_send,
//                                                 tone_change, tone_broadcast,
//                                                 frame_status
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each request waits in the input register and yields one result in the result
// register when it advances, which also updates the timers and frame state. A
// new request can be accepted in every cycle while the result channel does not
// stall.
// Reset clears the byte count, the timers, the motor and tone state and loads
// the register defaults. A stalled result holds the result register, and one
// more request waits in the input register before in_stall_o rises.
// ----------------------------------------------------------------------------
module radio_command_frame_controller import rcfc_pkg::*; #(
  parameter int unsigned MAX_RX_BYTES     = 16,
  parameter int unsigned REQUEST_DELAY_MS = 300
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_op_i,
  input  logic [7:0]         in_rx_byte_i,
  input  logic               in_rx_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_drive_on_o,
  output logic               out_telemetry_send_o,
  output logic               out_tone_change_o,
  output logic               out_tone_broadcast_o,
  output logic [2:0]         out_frame_status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t       cfg_q;
  logic       in_vld_q, in_vld_d;
  logic       op_q, last_q;
  logic [7:0] byte_q;
  logic       out_vld_q, out_vld_d;
  result_t    res_q, res_d;
  frame_chk_t chk;
  logic       advance, in_take;

  assign advance   = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take   = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? 1'b1 : ((out_vld_q && out_stall_i) ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= in_op_i;
      byte_q <= in_rx_byte_i;
      last_q <= in_rx_last_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word           <= 16'd0;
      cfg_q.own_id              <= 16'd0;
      cfg_q.broadcast_id        <= 16'hFFFF;
      cfg_q.code_drive_on       <= 8'd1;
      cfg_q.code_motor_off      <= 8'd2;
      cfg_q.code_telemetry      <= 8'd3;
      cfg_q.failsafe_ms         <= 16'd1000;
      cfg_q.telemetry_period_ms <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegSyncWord:     cfg_q.sync_word           <= cfg_data_i;
        RegOwnId:        cfg_q.own_id              <= cfg_data_i;
        RegBroadcastId:  cfg_q.broadcast_id        <= cfg_data_i;
        RegCodeMotorOn:  cfg_q.code_drive_on       <= cfg_data_i[7:0];
        RegCodeMotorOff: cfg_q.code_motor_off      <= cfg_data_i[7:0];
        RegCodeTelem:    cfg_q.code_telemetry      <= cfg_data_i[7:0];
        RegFailsafeMs:   cfg_q.failsafe_ms         <= cfg_data_i;
        RegTelemPeriod:  cfg_q.telemetry_period_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcfc_frame #(
    .MaxRxBytes(MAX_RX_BYTES)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(advance && op_q),
    .rx_byte_i(byte_q),
    .rx_last_i(last_q),
    .cfg_i    (cfg_q),
    .chk_o    (chk)
  );

  rcfc_ctrl #(
    .ReqDelayMs(REQUEST_DELAY_MS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_i   (advance),
    .op_i     (op_q),
    .rx_last_i(last_q),
    .chk_i    (chk),
    .cfg_i    (cfg_q),
    .res_o    (res_d)
  );

  assign out_valid_o          = out_vld_q;
  assign out_drive_on_o       = res_q.drive_on;
  assign out_telemetry_send_o = res_q.telemetry_send;
  assign out_tone_change_o    = res_q.tone_change;
  assign out_tone_broadcast_o = res_q.tone_broadcast;
  assign out_frame_status_o   = res_q.frame_status;

endmodule

>>> hdl/rcfc_checker.sv
// ----------------------------------------------------------------------------
// Radio command frame controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rcfc_checker import rcfc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       out_telemetry_send_o,
  input logic       out_tone_change_o,
  input logic       out_tone_broadcast_o,
  input logic [2:0] out_frame_status_o
);

  // A telemetry send only comes from a tick, which never carries frame status.
  a_send_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_telemetry_send_o) |->
      (out_frame_status_o == StNone) && !out_tone_change_o)
    else $error("telemetry send together with frame status or tone change");

  // The tone only changes on an accepted frame.
  a_tone_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_tone_change_o) |-> (out_frame_status_o == StAccepted))
    else $error("tone change without an accepted frame");

  // Broadcast mode only moves on a result that reports a tone change.
  a_mode_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i ##1 out_valid_o && !out_tone_change_o &&
     out_frame_status_o != StAccepted) |->
      (out_tone_broadcast_o == $past(out_tone_broadcast_o)))
    else $error("tone mode changed without an accepted frame");

  // A stalled result stays valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind radio_command_frame_controller rcfc_checker u_rcfc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_telemetry_send_o(out_telemetry_send_o),
  .out_tone_change_o   (out_tone_change_o),
  .out_tone_broadcast_o(out_tone_broadcast_o),
  .out_frame_status_o  (out_frame_status_o)
);
